// ===== rtl/bbc_pkg.sv =====
`timescale 1ns / 1ps
// bbc_pkg: shared constants, symbol codes and command types of the bracket checker
// used by the modules and the input interface of the bracket checker, depends on nothing

package bbc_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 256;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // symbol width and bracket codes
  localparam int SYM_W = 8;
  localparam logic [SYM_W-1:0] SYM_OPEN_ROUND   = 8'h28;
  localparam logic [SYM_W-1:0] SYM_CLOSE_ROUND  = 8'h29;
  localparam logic [SYM_W-1:0] SYM_OPEN_SQUARE  = 8'h5B;
  localparam logic [SYM_W-1:0] SYM_CLOSE_SQUARE = 8'h5D;

  // stack entry kinds
  localparam logic KIND_ROUND  = 1'b0;
  localparam logic KIND_SQUARE = 1'b1;

  // classified operation of one item
  typedef enum logic [2:0] {
    OP_NONE,
    OP_OPEN_ROUND,
    OP_OPEN_SQUARE,
    OP_CLOSE_ROUND,
    OP_CLOSE_SQUARE,
    OP_OTHER
  } op_t;

  // command passed from the front end to the stack engine
  typedef struct packed {
    op_t  op;
    logic eol;
  } cmd_t;

endpackage

// ===== rtl/bbc_in_if.sv =====
`timescale 1ns / 1ps
// bbc_in_if: input channel of the bracket checker, one symbol item per handshake
// depends on bbc_pkg for the symbol width

interface bbc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bbc_pkg::SYM_W-1:0]  symbol;
  logic                       has_symbol;
  logic                       end_of_line;

  modport source (output valid, output symbol, output has_symbol, output end_of_line,
                  input ready);
  modport sink   (input valid, input symbol, input has_symbol, input end_of_line,
                  output ready);
endinterface

// ===== rtl/bbc_out_if.sv =====
`timescale 1ns / 1ps
// bbc_out_if: result channel of the bracket checker, one line verdict per handshake
// depends on nothing

interface bbc_out_if;
  logic valid;
  logic ready;
  logic balanced;
  logic overflowed;

  modport source (output valid, output balanced, output overflowed, input ready);
  modport sink   (input valid, input balanced, input overflowed, output ready);
endinterface

// ===== rtl/bracket_balance_checker_top.sv =====
`timescale 1ns / 1ps
// bracket_balance_checker_top: bracket balance checker, front end, queue and stack engine
// depends on bbc_pkg, bbc_in_if, bbc_out_if, bbc_front, bbc_queue and bbc_back
//
//   channel   dir  payload                              meaning
//   in_item   in   symbol[7:0], has_symbol, end_of_line  one byte of a line
//   out_item  out  balanced, overflowed                  verdict at each line end
//
// One item is taken per cycle while the queue has room; a line verdict travels from its
// end-marked item through the command queue and the result register onto out_item, and
// is delayed further only while an unread verdict holds the queue back. The stack
// keeps its top two entries in flops, so a pop right after a pop reads the memory
// one entry ahead. Reset is synchronous and clears all control; the stack memory
// needs no clearing. Input stalls only when the four-entry queue fills behind an
// unread verdict.

module bracket_balance_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  bbc_in_if.sink     in_item,
  bbc_out_if.source  out_item
);

  logic           fq_valid, fq_ready;
  bbc_pkg::cmd_t  fq_cmd;
  logic           qb_valid, qb_ready;
  bbc_pkg::cmd_t  qb_cmd;

  // classify incoming items
  bbc_front u_front (
    .in_item   (in_item),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  // decouple front end and stack engine
  bbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  // run stack commands and report verdicts
  bbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/bbc_front.sv =====
`timescale 1ns / 1ps
// bbc_front: accepts input items and classifies each symbol into a stack command
// depends on bbc_pkg and bbc_in_if

module bbc_front (
  bbc_in_if.sink         in_item,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output bbc_pkg::cmd_t  cmd
);

  bbc_pkg::op_t op;

  // symbol decode
  always_comb begin
    op = bbc_pkg::OP_NONE;
    if (in_item.has_symbol) begin
      case (in_item.symbol)
        bbc_pkg::SYM_OPEN_ROUND:   op = bbc_pkg::OP_OPEN_ROUND;
        bbc_pkg::SYM_OPEN_SQUARE:  op = bbc_pkg::OP_OPEN_SQUARE;
        bbc_pkg::SYM_CLOSE_ROUND:  op = bbc_pkg::OP_CLOSE_ROUND;
        bbc_pkg::SYM_CLOSE_SQUARE: op = bbc_pkg::OP_CLOSE_SQUARE;
        default:                   op = bbc_pkg::OP_OTHER;
      endcase
    end
  end

  // handshake toward the command queue
  assign cmd.op        = op;
  assign cmd.eol       = in_item.end_of_line;
  assign cmd_valid     = in_item.valid;
  assign in_item.ready = cmd_ready;

endmodule

// ===== rtl/bbc_queue.sv =====
`timescale 1ns / 1ps
// bbc_queue: small command queue between the front end and the stack engine
// depends on bbc_pkg for the command type and queue depth

module bbc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  bbc_pkg::cmd_t  wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output bbc_pkg::cmd_t  rd_cmd
);

  bbc_pkg::cmd_t                 slot_r [bbc_pkg::QUEUE_DEPTH];
  logic [bbc_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bbc_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bbc_pkg::Q_CNT_W-1:0]   fill_r, fill_nxt;
  logic                          do_wr, do_rd;

  // status and handshakes
  assign wr_ready = (fill_r != bbc_pkg::Q_CNT_W'(bbc_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // pointer and fill arithmetic
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == bbc_pkg::Q_PTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == bbc_pkg::Q_PTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/bbc_back.sv =====
`timescale 1ns / 1ps
// bbc_back: stack engine that runs bracket commands and reports one verdict per line
// depends on bbc_pkg and bbc_out_if

module bbc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bbc_pkg::cmd_t  cmd,
  bbc_out_if.source      out_item
);

  // kind stack storage, top two entries cached in flops
  logic                        kind_mem [bbc_pkg::STACK_DEPTH];
  logic                        mem_q_r;

  logic [bbc_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        failed_r, failed_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        top_r, top_nxt;
  logic                        below_hold_r, below_hold_nxt;
  logic                        below_sel_mem_r, below_sel_mem_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_balanced_r, out_balanced_nxt;
  logic                        out_overflowed_r, out_overflowed_nxt;

  logic                        go, do_push, do_pop, push_kind, below;
  logic                        line_fail, line_ovf;
  logic [bbc_pkg::CNT_W-1:0]   line_count;
  logic [bbc_pkg::CNT_W-1:0]   rd_idx;

  assign below     = below_sel_mem_r ? mem_q_r : below_hold_r;
  assign rd_idx    = count_r - bbc_pkg::CNT_W'(3);
  assign cmd_ready = !cmd.eol || !out_valid_r || out_item.ready;
  assign go        = cmd_valid && cmd_ready;

  // per-command stack decision
  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    push_kind  = bbc_pkg::KIND_ROUND;
    line_fail  = failed_r;
    line_ovf   = ovf_r;
    line_count = count_r;
    if (go && !failed_r) begin
      case (cmd.op)
        bbc_pkg::OP_OPEN_ROUND, bbc_pkg::OP_OPEN_SQUARE: begin
          push_kind = (cmd.op == bbc_pkg::OP_OPEN_SQUARE) ?
                      bbc_pkg::KIND_SQUARE : bbc_pkg::KIND_ROUND;
          if (count_r == bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH)) begin
            line_fail = 1'b1;
            line_ovf  = 1'b1;
          end else begin
            do_push    = 1'b1;
            line_count = count_r + 1'b1;
          end
        end
        bbc_pkg::OP_CLOSE_ROUND, bbc_pkg::OP_CLOSE_SQUARE, bbc_pkg::OP_OTHER: begin
          if (count_r == '0) begin
            line_fail = 1'b1;
          end else if (cmd.op == bbc_pkg::OP_CLOSE_SQUARE &&
                       top_r != bbc_pkg::KIND_SQUARE) begin
            line_fail = 1'b1;
          end else if (cmd.op == bbc_pkg::OP_CLOSE_ROUND &&
                       top_r != bbc_pkg::KIND_ROUND) begin
            line_fail = 1'b1;
          end else begin
            do_pop     = 1'b1;
            line_count = count_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // line state, top-of-stack cache and result register
  always_comb begin
    count_nxt          = line_count;
    failed_nxt         = line_fail;
    ovf_nxt            = line_ovf;
    top_nxt            = top_r;
    below_hold_nxt     = below_hold_r;
    below_sel_mem_nxt  = below_sel_mem_r;
    out_valid_nxt      = out_valid_r && !out_item.ready;
    out_balanced_nxt   = out_balanced_r;
    out_overflowed_nxt = out_overflowed_r;

    // push shifts the cache down, pop pulls the next entry up
    if (do_push) begin
      top_nxt           = push_kind;
      below_hold_nxt    = top_r;
      below_sel_mem_nxt = 1'b0;
    end else if (do_pop) begin
      top_nxt           = below;
      below_sel_mem_nxt = 1'b1;
    end

    // end of line: report and clear
    if (go && cmd.eol) begin
      out_valid_nxt      = 1'b1;
      out_balanced_nxt   = !line_fail && (line_count == '0);
      out_overflowed_nxt = line_ovf;
      count_nxt          = '0;
      failed_nxt         = 1'b0;
      ovf_nxt            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r         <= '0;
      failed_r        <= 1'b0;
      ovf_r           <= 1'b0;
      below_sel_mem_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      count_r         <= count_nxt;
      failed_r        <= failed_nxt;
      ovf_r           <= ovf_nxt;
      below_sel_mem_r <= below_sel_mem_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r            <= top_nxt;
    below_hold_r     <= below_hold_nxt;
    out_balanced_r   <= out_balanced_nxt;
    out_overflowed_r <= out_overflowed_nxt;
  end

  // stack memory: write on push, registered read of the third entry on pop
  always_ff @(posedge clk) begin
    if (do_push) begin
      kind_mem[count_r[bbc_pkg::ADDR_W-1:0]] <= push_kind;
    end
    if (do_pop) begin
      mem_q_r <= kind_mem[rd_idx[bbc_pkg::ADDR_W-1:0]];
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.balanced   = out_balanced_r;
  assign out_item.overflowed = out_overflowed_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for bracket_balance_checker_top; streams lines of bytes and
// checks every line verdict against a bench bracket stack model or a verdict typed in a directed row
// depends on bbc_pkg, bbc_in_if, bbc_out_if and the bracket checker rtl

module tb_top;

  localparam int ITEM_BUDGET   = 1250;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_PRINTED   = 30;

  localparam logic [bbc_pkg::SYM_W-1:0] BRACKETS [4] = '{
    bbc_pkg::SYM_OPEN_ROUND, bbc_pkg::SYM_CLOSE_ROUND,
    bbc_pkg::SYM_OPEN_SQUARE, bbc_pkg::SYM_CLOSE_SQUARE};

  typedef struct packed {
    logic balanced;
    logic overflowed;
  } verdict_t;

  typedef struct packed {
    logic [bbc_pkg::SYM_W-1:0] symbol;
    logic                      has_symbol;
    logic                      end_of_line;
    logic                      typed;
    logic                      exp_balanced;
    logic                      exp_overflowed;
  } step_row_t;

  typedef logic [bbc_pkg::SYM_W-1:0] byte_q_t [$];

  logic clk = 1'b0;
  logic rst_n;

  bbc_in_if  in_item ();
  bbc_out_if out_item ();

  bracket_balance_checker_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bracket stack model of the current line
  bit          open_kinds [bbc_pkg::STACK_DEPTH];
  int unsigned open_depth    = 0;
  bit          line_broken   = 1'b0;
  bit          line_overflow = 1'b0;

  // line verdicts still owed by the block, oldest first
  verdict_t pending_verdicts [$];

  int unsigned items_sent      = 0;
  int unsigned lines_checked   = 0;
  int unsigned deepest_nesting = 0;
  int unsigned overflow_lines  = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;

  // sender burst state
  int unsigned burst_left   = 0;
  bit          sender_eager = 1'b0;

  // directed lines: empty, matched pairs, wrong kinds, closes and plain bytes on an
  // empty stack, plain byte popping either kind, ignored symbol on an end-only item,
  // unclosed opens and a sticky failure
  step_row_t directed_rows [23] = '{
    '{8'h00,                     1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{bbc_pkg::SYM_OPEN_ROUND,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{bbc_pkg::SYM_CLOSE_ROUND,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{bbc_pkg::SYM_OPEN_SQUARE,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{bbc_pkg::SYM_CLOSE_SQUARE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{bbc_pkg::SYM_OPEN_ROUND,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{bbc_pkg::SYM_CLOSE_SQUARE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{bbc_pkg::SYM_OPEN_SQUARE,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{bbc_pkg::SYM_CLOSE_ROUND,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{bbc_pkg::SYM_CLOSE_ROUND,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{8'h00,                     1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{bbc_pkg::SYM_OPEN_ROUND,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hFF,                     1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{bbc_pkg::SYM_OPEN_SQUARE,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h41,                     1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hA5,                     1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{bbc_pkg::SYM_OPEN_ROUND,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{bbc_pkg::SYM_CLOSE_ROUND,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{bbc_pkg::SYM_OPEN_SQUARE,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{bbc_pkg::SYM_CLOSE_SQUARE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{bbc_pkg::SYM_OPEN_SQUARE,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{bbc_pkg::SYM_CLOSE_SQUARE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{bbc_pkg::SYM_OPEN_ROUND,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  // one byte through the bracket stack; a broken line ignores everything
  function automatic void take_byte(input logic [bbc_pkg::SYM_W-1:0] sym);
    if (line_broken) begin
      return;
    end
    if (sym == bbc_pkg::SYM_OPEN_ROUND || sym == bbc_pkg::SYM_OPEN_SQUARE) begin
      if (open_depth >= bbc_pkg::STACK_DEPTH) begin
        line_broken   = 1'b1;
        line_overflow = 1'b1;
      end else begin
        open_kinds[open_depth] = (sym == bbc_pkg::SYM_OPEN_SQUARE) ?
                                 bbc_pkg::KIND_SQUARE : bbc_pkg::KIND_ROUND;
        open_depth++;
      end
    end else if (open_depth == 0) begin
      line_broken = 1'b1;
    end else if ((sym == bbc_pkg::SYM_CLOSE_SQUARE &&
                  open_kinds[open_depth-1] != bbc_pkg::KIND_SQUARE) ||
                 (sym == bbc_pkg::SYM_CLOSE_ROUND &&
                  open_kinds[open_depth-1] != bbc_pkg::KIND_ROUND)) begin
      line_broken = 1'b1;
    end else begin
      open_depth--;
    end
  endfunction

  // verdict at line end, then a clean stack for the next line
  function automatic verdict_t finish_line();
    verdict_t v;
    v.balanced    = !line_broken && open_depth == 0;
    v.overflowed  = line_overflow;
    open_depth    = 0;
    line_broken   = 1'b0;
    line_overflow = 1'b0;
    return v;
  endfunction

  // any byte other than the four brackets
  function automatic logic [bbc_pkg::SYM_W-1:0] plain_byte();
    logic [bbc_pkg::SYM_W-1:0] b;
    do
      b = bbc_pkg::SYM_W'($urandom_range(0, 255));
    while (b == bbc_pkg::SYM_OPEN_ROUND || b == bbc_pkg::SYM_CLOSE_ROUND ||
           b == bbc_pkg::SYM_OPEN_SQUARE || b == bbc_pkg::SYM_CLOSE_SQUARE);
    return b;
  endfunction

  // well-formed nesting of random kinds; some closes are plain bytes, which pop too
  function automatic void add_nested(ref byte_q_t q, input int unsigned pairs,
                                     input int unsigned max_depth);
    bit          kinds [$];
    int unsigned opens_left;
    opens_left = pairs;
    while (opens_left > 0 || kinds.size() > 0) begin
      if (opens_left > 0 && kinds.size() < max_depth &&
          (kinds.size() == 0 || $urandom_range(0, 1) == 1)) begin
        kinds.push_back(bit'($urandom_range(0, 1)));
        q.push_back(kinds[$] ? bbc_pkg::SYM_OPEN_SQUARE : bbc_pkg::SYM_OPEN_ROUND);
        opens_left--;
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          q.push_back(plain_byte());
        end else begin
          q.push_back(kinds[$] ? bbc_pkg::SYM_CLOSE_SQUARE : bbc_pkg::SYM_CLOSE_ROUND);
        end
        void'(kinds.pop_back());
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // drive one item at the falling edge, wait for its handshake, update the model
  task automatic send_item(input logic [bbc_pkg::SYM_W-1:0] sym, input logic has,
                           input logic eol, input logic typed,
                           input verdict_t typed_verdict);
    verdict_t    v;
    int unsigned gap;
    if (!sender_eager && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        in_item.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_item.valid       <= 1'b1;
    in_item.symbol      <= sym;
    in_item.has_symbol  <= has;
    in_item.end_of_line <= eol;
    do @(posedge clk); while (in_item.ready !== 1'b1);
    if (has) begin
      take_byte(sym);
    end
    if (open_depth > deepest_nesting) begin
      deepest_nesting = open_depth;
    end
    if (eol) begin
      v = finish_line();
      if (v.overflowed) begin
        overflow_lines++;
      end
      pending_verdicts.push_back(typed ? typed_verdict : v);
    end
    if (has || eol) begin
      items_sent++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
  endtask

  task automatic send_checked(input logic [bbc_pkg::SYM_W-1:0] sym, input logic has,
                              input logic eol);
    send_item(sym, has, eol, 1'b0, verdict_t'(2'b00));
  endtask

  // result receiver: ready follows a 16-bit stall pattern that is periodically redrawn
  initial begin
    logic [15:0] stall_pattern;
    int unsigned phase;
    out_item.ready = 1'b0;
    stall_pattern  = 16'hFFFF;
    phase          = 0;
    forever begin
      @(negedge clk);
      if (phase % 64 == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          stall_pattern = 16'hFFFF;
        end else begin
          stall_pattern = 16'($urandom()) | (16'h1 << $urandom_range(0, 15));
        end
      end
      out_item.ready <= stall_pattern[phase % 16];
      phase++;
    end
  end

  // verdict checker
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_item.valid === 1'b1 && out_item.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict balanced=%b overflowed=%b with no line pending",
                                  out_item.balanced, out_item.overflowed));
      end else begin
        want = pending_verdicts.pop_front();
        lines_checked++;
        if (out_item.balanced !== want.balanced) begin
          report_mismatch($sformatf("line %0d balanced=%b, model says %b", lines_checked,
                                    out_item.balanced, want.balanced));
        end
        if (out_item.overflowed !== want.overflowed) begin
          report_mismatch($sformatf("line %0d overflowed=%b, model says %b", lines_checked,
                                    out_item.overflowed, want.overflowed));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d verdicts outstanding", cycle_count,
               pending_verdicts.size());
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    byte_q_t     line_bytes;
    int unsigned line_no;
    int unsigned pick;
    int unsigned spot;
    bit          close_on_last;
    rst_n               = 1'b0;
    in_item.valid       = 1'b0;
    in_item.symbol      = '0;
    in_item.has_symbol  = 1'b0;
    in_item.end_of_line = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed lines
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].symbol, directed_rows[i].has_symbol,
                directed_rows[i].end_of_line, directed_rows[i].typed,
                verdict_t'({directed_rows[i].exp_balanced, directed_rows[i].exp_overflowed}));
    end

    // random lines
    line_no = 0;
    while (items_sent < ITEM_BUDGET) begin
      line_bytes.delete();
      if (line_no == 6) begin
        // fill every stack entry, then unwind with matching closes
        repeat (bbc_pkg::STACK_DEPTH) begin
          line_bytes.push_back($urandom_range(0, 1) ? bbc_pkg::SYM_OPEN_SQUARE
                                                    : bbc_pkg::SYM_OPEN_ROUND);
        end
        for (int i = bbc_pkg::STACK_DEPTH - 1; i >= 0; i--) begin
          line_bytes.push_back(line_bytes[i] == bbc_pkg::SYM_OPEN_SQUARE ?
                               bbc_pkg::SYM_CLOSE_SQUARE : bbc_pkg::SYM_CLOSE_ROUND);
        end
      end else if (line_no == 18) begin
        // push past full depth, then some bytes the broken line must ignore
        repeat (bbc_pkg::STACK_DEPTH + $urandom_range(1, 3)) begin
          line_bytes.push_back($urandom_range(0, 1) ? bbc_pkg::SYM_OPEN_SQUARE
                                                    : bbc_pkg::SYM_OPEN_ROUND);
        end
        repeat ($urandom_range(0, 4)) begin
          line_bytes.push_back(BRACKETS[$urandom_range(0, 3)]);
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          add_nested(line_bytes, $urandom_range(20, 40), 40);
        end else if (pick < 55) begin
          add_nested(line_bytes, $urandom_range(1, 8), $urandom_range(1, 8));
        end else if (pick < 75) begin
          // well-formed line with one byte changed, dropped or added
          add_nested(line_bytes, $urandom_range(1, 8), 8);
          spot = $urandom_range(0, line_bytes.size() - 1);
          case ($urandom_range(0, 2))
            0: begin
              line_bytes[spot] = bbc_pkg::SYM_W'($urandom_range(0, 255));
            end
            1: begin
              line_bytes.delete(spot);
            end
            default: begin
              line_bytes.insert(spot, BRACKETS[$urandom_range(0, 3)]);
            end
          endcase
        end else if (pick < 92) begin
          // noise, about half brackets
          repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 1) == 0) begin
              line_bytes.push_back(BRACKETS[$urandom_range(0, 3)]);
            end else begin
              line_bytes.push_back(bbc_pkg::SYM_W'($urandom_range(0, 255)));
            end
          end
        end
      end

      sender_eager  = ($urandom_range(0, 3) == 0);
      close_on_last = ($urandom_range(0, 2) != 0);
      foreach (line_bytes[k]) begin
        // stray item with no symbol and no end mark
        if ($urandom_range(0, 15) == 0) begin
          send_checked(bbc_pkg::SYM_W'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        send_checked(line_bytes[k], 1'b1, close_on_last && k == line_bytes.size() - 1);
      end
      if (!close_on_last || line_bytes.size() == 0) begin
        send_checked(bbc_pkg::SYM_W'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      line_no++;
    end

    // drain
    in_item.valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d line verdicts checked, %0d mismatches", items_sent,
             lines_checked, mismatches);
    $display("deepest nesting %0d of %0d, %0d lines ran past the stack", deepest_nesting,
             bbc_pkg::STACK_DEPTH, overflow_lines);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bbc_pkg.sv
rtl/bbc_in_if.sv
rtl/bbc_out_if.sv
rtl/bbc_front.sv
rtl/bbc_queue.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker_top.sv
verif/tb_top.sv
